@@ design/mci_pkg.sv @@
// Shared types and constants for the marker codeword identify unit.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package mci_pkg;

	localparam int MAX_ENTRIES_DEF = 4096;
	localparam int MAX_SIDE_DEF    = 8;
	localparam int MIN_SIDE        = 4;
	localparam int NUM_ROT         = 4;

	localparam int SIDE_W    = 4;
	localparam int ENTRIES_W = 13;
	localparam int LIMIT_W   = 5;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int INDEX_W   = 12;
	localparam int CELLS_W   = 64;
	localparam int ROT_W     = 2;

	// request codes carried by req_type
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_IDENT = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_SIDE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ENTRIES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_LIMIT = 2'd2;

	typedef struct packed {
		logic [SIDE_W-1:0]    marker_side;
		logic [ENTRIES_W-1:0] active_entries;
		logic [LIMIT_W-1:0]   correction_limit;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // write the four rotations of the presented word
		logic start_scan;  // latch candidate, clear match record, rewind address
		logic issue;       // read one entry and advance the address
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic no_entries;
		logic last_issue;
		logic pipe_empty;
	} sts_t;

endpackage

`default_nettype wire

@@ design/mci_ctrl.sv @@
// Sequencing controller of the marker codeword identify unit.
// Depends on mci_pkg for the command and status structs.
`default_nettype none

module mci_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          req_type,
	input  wire mci_pkg::sts_t sts,
	output mci_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept = start && !busy_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = accept && (req_type == mci_pkg::REQ_LOAD);
		cmd.start_scan = accept && (req_type == mci_pkg::REQ_IDENT);
		cmd.issue      = (state_q == ST_SCAN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == mci_pkg::REQ_LOAD || sts.no_entries) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
							busy_q  <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (sts.last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait for the last entry to leave the compare pipeline
					if (sts.pipe_empty) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

`default_nettype wire

@@ design/mci_datapath.sv @@
// Datapath of the marker codeword identify unit: rotation network, code memory,
// pipelined Hamming compare and match record. Depends on mci_pkg.
`default_nettype none

module mci_datapath #(
	parameter int MAX_ENTRIES = mci_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_SIDE    = mci_pkg::MAX_SIDE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire mci_pkg::cfg_t                   cfg,
	input  wire mci_pkg::cmd_t                   cmd,
	input  wire logic [mci_pkg::INDEX_W-1:0]     entry_index,
	input  wire logic [mci_pkg::CELLS_W-1:0]     cell_bits,
	output mci_pkg::sts_t                        sts,
	output logic                                 found,
	output logic [mci_pkg::INDEX_W-1:0]          marker_id,
	output logic [mci_pkg::ROT_W-1:0]            rotation_found
);

	localparam int NR = mci_pkg::NUM_ROT;
	localparam int CW = MAX_SIDE * MAX_SIDE;
	localparam int NC = (CW + 7) / 8;
	localparam int PW = NC * 8;
	localparam int DW = $clog2(CW + 1);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NW = $clog2(MAX_ENTRIES + 1);

	logic [mci_pkg::SIDE_W-1:0] side_eff;
	logic [CW-1:0]              mask_w;
	logic [CW-1:0]              cand_w;
	logic [CW-1:0]              rot_w [NR];
	logic [NW-1:0]              n_eff;
	logic [31:0]                slot_w;
	logic                       slot_ok;

	logic [CW-1:0]    cand_q;
	logic [CW-1:0]    mask_q;
	logic [AW-1:0]    addr_q;
	logic [NR*CW-1:0] mem [MAX_ENTRIES];

	logic             v_s1, v_s2, v_s3;
	logic [AW-1:0]    idx_s1, idx_s2, idx_s3;
	logic [NR*CW-1:0] row_s1;
	logic [3:0]       cnt_w  [NR][NC];
	logic [3:0]       cnt_s2 [NR][NC];
	logic [DW-1:0]    dist_w  [NR];
	logic [DW-1:0]    dist_s3 [NR];

	logic [DW-1:0]             best_w;
	logic [mci_pkg::ROT_W-1:0] best_rot_w;
	logic                      ex_hit_w;
	logic [mci_pkg::ROT_W-1:0] ex_rot_w;
	logic                      hit_w;
	logic [mci_pkg::ROT_W-1:0] hit_rot_w;

	logic                      found_q;
	logic [AW-1:0]             id_q;
	logic [mci_pkg::ROT_W-1:0] rot_q;
	logic [31:0]               id_w;

	// clamp the side to the supported range
	always_comb begin
		if (cfg.marker_side < mci_pkg::SIDE_W'(mci_pkg::MIN_SIDE)) begin
			side_eff = mci_pkg::SIDE_W'(mci_pkg::MIN_SIDE);
		end else if (cfg.marker_side > mci_pkg::SIDE_W'(MAX_SIDE)) begin
			side_eff = mci_pkg::SIDE_W'(MAX_SIDE);
		end else begin
			side_eff = cfg.marker_side;
		end
	end

	always_comb begin
		for (int i = 0; i < CW; i++) begin
			mask_w[i] = (i < int'(side_eff) * int'(side_eff));
		end
	end

	assign cand_w = cell_bits[CW-1:0] & mask_w;

	// quarter-turn wiring, one set per legal side, picked by the clamped side
	always_comb begin
		for (int r = 0; r < NR; r++) begin
			rot_w[r] = '0;
		end
		for (int sd = mci_pkg::MIN_SIDE; sd <= MAX_SIDE; sd++) begin
			if (side_eff == mci_pkg::SIDE_W'(sd)) begin
				for (int row = 0; row < sd; row++) begin
					for (int col = 0; col < sd; col++) begin
						rot_w[0][row*sd+col] = cand_w[row*sd+col];
						rot_w[1][row*sd+col] = cand_w[col*sd+(sd-1-row)];
						rot_w[2][row*sd+col] = cand_w[(sd-1-row)*sd+(sd-1-col)];
						rot_w[3][row*sd+col] = cand_w[(sd-1-col)*sd+row];
					end
				end
			end
		end
	end

	assign slot_w  = 32'(entry_index);
	assign slot_ok = (int'(slot_w) < MAX_ENTRIES);

	always_comb begin
		if (32'(cfg.active_entries) > 32'(MAX_ENTRIES)) begin
			n_eff = NW'(MAX_ENTRIES);
		end else begin
			n_eff = NW'(cfg.active_entries);
		end
	end

	// code memory: one row holds all four rotations of an entry
	always_ff @(posedge clk) begin
		if (cmd.load && slot_ok) begin
			mem[slot_w[AW-1:0]] <= {rot_w[3], rot_w[2], rot_w[1], rot_w[0]};
		end
		if (cmd.issue) begin
			row_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_scan) begin
			cand_q <= cand_w;
			mask_q <= mask_w;
		end
	end

	// per-byte population counts of the masked difference
	always_comb begin
		logic [PW-1:0] diff;
		logic [3:0]    acc;
		for (int r = 0; r < NR; r++) begin
			diff = PW'((row_s1[r*CW +: CW] ^ cand_q) & mask_q);
			for (int c = 0; c < NC; c++) begin
				acc = '0;
				for (int b = 0; b < 8; b++) begin
					acc = acc + 4'(diff[c*8+b]);
				end
				cnt_w[r][c] = acc;
			end
		end
	end

	always_comb begin
		logic [DW-1:0] sum;
		for (int r = 0; r < NR; r++) begin
			sum = '0;
			for (int c = 0; c < NC; c++) begin
				sum = sum + DW'(cnt_s2[r][c]);
			end
			dist_w[r] = sum;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		for (int r = 0; r < NR; r++) begin
			for (int c = 0; c < NC; c++) begin
				cnt_s2[r][c] <= cnt_w[r][c];
			end
			dist_s3[r] <= dist_w[r];
		end
	end

	// best rotation (lowest wins ties) and exact match (last wins)
	always_comb begin
		best_w     = dist_s3[0];
		best_rot_w = '0;
		ex_hit_w   = 1'b0;
		ex_rot_w   = '0;
		for (int r = 1; r < NR; r++) begin
			if (dist_s3[r] < best_w) begin
				best_w     = dist_s3[r];
				best_rot_w = mci_pkg::ROT_W'(r);
			end
		end
		for (int r = 0; r < NR; r++) begin
			if (dist_s3[r] == '0) begin
				ex_hit_w = 1'b1;
				ex_rot_w = mci_pkg::ROT_W'(r);
			end
		end
		if (cfg.correction_limit != '0) begin
			hit_w     = !found_q && (32'(best_w) <= 32'(cfg.correction_limit));
			hit_rot_w = best_rot_w;
		end else begin
			hit_w     = ex_hit_w;
			hit_rot_w = ex_rot_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			found_q <= 1'b0;
			id_q    <= '0;
			rot_q   <= '0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.start_scan) begin
				addr_q <= '0;
			end else if (cmd.issue) begin
				addr_q <= addr_q + 1'b1;
			end
			if (cmd.load || cmd.start_scan) begin
				found_q <= 1'b0;
				id_q    <= '0;
				rot_q   <= '0;
			end else if (v_s3 && hit_w) begin
				found_q <= 1'b1;
				id_q    <= idx_s3;
				rot_q   <= hit_rot_w;
			end
		end
	end

	always_comb begin
		sts            = '0;
		sts.no_entries = (n_eff == '0);
		sts.last_issue = (32'(addr_q) + 32'd1 == 32'(n_eff));
		sts.pipe_empty = !v_s1 && !v_s2 && !v_s3;
	end

	assign id_w           = 32'(id_q);
	assign found          = found_q;
	assign marker_id      = id_w[mci_pkg::INDEX_W-1:0];
	assign rotation_found = rot_q;

endmodule

`default_nettype wire

@@ design/marker_codeword_identify_unit.sv @@
// Top level of the marker codeword identify unit: configuration registers,
// controller and datapath. Depends on mci_pkg, mci_ctrl and mci_datapath.
`default_nettype none

// Raise start for a word while busy is low; the word is taken at that edge.
// Each word yields exactly one result, shown for a single cycle with done
// high. The receiver has no way to hold a result back, so capture found,
// marker_id and rotation_found whenever done is high. A load word writes the
// four quarter turns of the grid and strobes an all-zero result on the next
// cycle; busy never rises, so loads may follow one per cycle. An identify word
// keeps busy high while it scans N entries and drains, N being active_entries
// clamped to MAX_ENTRIES, and done rises in the same cycle as busy falls: the
// code memory has one read port and delivers one entry (all four rotations,
// compared side by side) per cycle, followed by a three-stage compare
// pipeline. With no active entries the result follows on the next cycle.
// A new word may be presented in the cycle that carries done. Write the
// configuration registers only while no word is in flight. The code memory
// has no reset: identify only against entries that have been loaded.

module marker_codeword_identify_unit #(
	parameter int MAX_ENTRIES = mci_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_SIDE    = mci_pkg::MAX_SIDE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command channel
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          req_type,
	input  wire logic [mci_pkg::INDEX_W-1:0]   entry_index,
	input  wire logic [mci_pkg::CELLS_W-1:0]   cell_bits,
	// result channel
	output logic                               done,
	output logic                               found,
	output logic [mci_pkg::INDEX_W-1:0]        marker_id,
	output logic [mci_pkg::ROT_W-1:0]          rotation_found,
	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [mci_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mci_pkg::CFG_W-1:0]     cfg_wdata
);

	mci_pkg::cfg_t cfg_q;
	mci_pkg::cmd_t cmd;
	mci_pkg::sts_t sts;

	// configuration registers; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.marker_side      <= mci_pkg::SIDE_W'(mci_pkg::MIN_SIDE);
			cfg_q.active_entries   <= '0;
			cfg_q.correction_limit <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mci_pkg::REG_MARKER_SIDE: begin
					cfg_q.marker_side <= cfg_wdata[mci_pkg::SIDE_W-1:0];
				end
				mci_pkg::REG_ACTIVE_ENTRIES: begin
					cfg_q.active_entries <= cfg_wdata[mci_pkg::ENTRIES_W-1:0];
				end
				mci_pkg::REG_CORRECTION_LIMIT: begin
					cfg_q.correction_limit <= cfg_wdata[mci_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	mci_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	mci_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MAX_SIDE    (MAX_SIDE)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.entry_index    (entry_index),
		.cell_bits      (cell_bits),
		.sts            (sts),
		.found          (found),
		.marker_id      (marker_id),
		.rotation_found (rotation_found)
	);

endmodule

`default_nettype wire

@@ tb/marker_codeword_identify_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for marker_codeword_identify_unit: a directed table of
// words, a fill of the low code-table slots, then randomised phases under sender idling.
// Depends on mci_pkg and the marker_codeword_identify_unit design files.

module marker_codeword_identify_unit_test;

	localparam int MAX_ENTRIES  = mci_pkg::MAX_ENTRIES_DEF;
	localparam int MAX_SIDE     = mci_pkg::MAX_SIDE_DEF;
	localparam int FILL_WORDS   = 24;
	localparam int PHASE_WORDS  = 16;
	localparam int NUM_PHASES   = 6;
	localparam int CYCLE_LIMIT  = 1_000_000;
	// index 3 decodes to no register; writes to it must change nothing
	localparam logic [mci_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// one result word as the block presents it
	typedef struct packed {
		logic                        hit;
		logic [mci_pkg::INDEX_W-1:0] id;
		logic [mci_pkg::ROT_W-1:0]   rot;
	} outcome_t;

	// one row of the directed script: either a register write or a word
	typedef struct packed {
		logic                          is_cfg;
		logic [mci_pkg::CFG_IDX_W-1:0] reg_idx;
		logic [mci_pkg::CFG_W-1:0]     wval;
		logic                          req;
		logic [mci_pkg::INDEX_W-1:0]   slot;
		logic [mci_pkg::CELLS_W-1:0]   cells;
		logic                          typed;
		outcome_t                      want;
	} stim_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          req_type;
	logic [mci_pkg::INDEX_W-1:0]   entry_index;
	logic [mci_pkg::CELLS_W-1:0]   cell_bits;
	logic                          done;
	logic                          found;
	logic [mci_pkg::INDEX_W-1:0]   marker_id;
	logic [mci_pkg::ROT_W-1:0]     rotation_found;
	logic                          cfg_we;
	logic [mci_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mci_pkg::CFG_W-1:0]     cfg_wdata;

	// predictor state: our own copy of the registers and of the rotation store
	logic [mci_pkg::SIDE_W-1:0]    m_side;
	logic [mci_pkg::ENTRIES_W-1:0] m_active;
	logic [mci_pkg::LIMIT_W-1:0]   m_limit;
	logic [mci_pkg::CELLS_W-1:0]   code_tab [0:MAX_ENTRIES*mci_pkg::NUM_ROT-1];

	outcome_t  pending [$];   // expected results, oldest first
	stim_row_t script [$];    // directed words and register writes

	int errors = 0;
	int cycle_count = 0;
	int n_words = 0, n_loads = 0, n_idents = 0, n_hits = 0, n_cfg = 0;
	int idle_pct [3] = '{0, 88, 29};

	marker_codeword_identify_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.entry_index    (entry_index),
		.cell_bits      (cell_bits),
		.done           (done),
		.found          (found),
		.marker_id      (marker_id),
		.rotation_found (rotation_found),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
			$display("marker_codeword_identify_unit_test: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Clamp the side register into the range the block supports.
	function automatic int unsigned clamp_side(logic [mci_pkg::SIDE_W-1:0] s);
		if (int'(s) < mci_pkg::MIN_SIDE)
			return 32'(mci_pkg::MIN_SIDE);
		if (int'(s) > MAX_SIDE)
			return 32'(MAX_SIDE);
		return 32'(s);
	endfunction

	// Cells beyond side squared take no part in loads or compares.
	function automatic logic [mci_pkg::CELLS_W-1:0] grid_mask(int unsigned side);
		int unsigned cells_n;
		cells_n = side * side;
		if (cells_n >= mci_pkg::CELLS_W)
			return '1;
		return (64'd1 << cells_n) - 64'd1;
	endfunction

	// Quarter-turn the grid; output cell (row, col) takes the source cell named
	// per turn count.
	function automatic logic [mci_pkg::CELLS_W-1:0] turn_grid(
			logic [mci_pkg::CELLS_W-1:0] g, int unsigned side, int unsigned quarter);
		logic [mci_pkg::CELLS_W-1:0] t;
		int unsigned src_r, src_c;
		t = '0;
		for (int unsigned row = 0; row < side; row++) begin
			for (int unsigned col = 0; col < side; col++) begin
				case (quarter)
					0: begin
						src_r = row;
						src_c = col;
					end
					1: begin
						src_r = col;
						src_c = side - 1 - row;
					end
					2: begin
						src_r = side - 1 - row;
						src_c = side - 1 - col;
					end
					default: begin
						src_r = side - 1 - col;
						src_c = row;
					end
				endcase
				t[row * side + col] = g[src_r * side + src_c];
			end
		end
		return t;
	endfunction

	// Work out the result of one accepted word and update the rotation store.
	function automatic outcome_t predict_word(logic req,
			logic [mci_pkg::INDEX_W-1:0] slot, logic [mci_pkg::CELLS_W-1:0] cells);
		outcome_t res;
		int unsigned side, n, best, best_q, hd;
		logic [mci_pkg::CELLS_W-1:0] mask, cand;
		side = clamp_side(m_side);
		mask = grid_mask(side);
		cand = cells & mask;
		res  = '0;
		n    = (int'(m_active) > MAX_ENTRIES) ? 32'(MAX_ENTRIES) : 32'(m_active);
		if (req == mci_pkg::REQ_LOAD) begin
			if (int'(slot) < MAX_ENTRIES)
				for (int unsigned q = 0; q < mci_pkg::NUM_ROT; q++)
					code_tab[slot * mci_pkg::NUM_ROT + q] = turn_grid(cand, side, q);
		end else if (m_limit != 0) begin
			// nearest match: first entry within the limit, first turn wins a tie
			for (int unsigned e = 0; e < n && !res.hit; e++) begin
				best   = side * side + 1;
				best_q = 0;
				for (int unsigned q = 0; q < mci_pkg::NUM_ROT; q++) begin
					hd = $countones((code_tab[e * mci_pkg::NUM_ROT + q] ^ cand) & mask);
					if (hd < best) begin
						best   = hd;
						best_q = q;
					end
				end
				if (best <= m_limit) begin
					res.hit = 1'b1;
					res.id  = mci_pkg::INDEX_W'(e);
					res.rot = mci_pkg::ROT_W'(best_q);
				end
			end
		end else begin
			// exact match: the last hit in entry-then-turn order is kept
			for (int unsigned e = 0; e < n; e++)
				for (int unsigned q = 0; q < mci_pkg::NUM_ROT; q++)
					if (((code_tab[e * mci_pkg::NUM_ROT + q] ^ cand) & mask) == '0) begin
						res.hit = 1'b1;
						res.id  = mci_pkg::INDEX_W'(e);
						res.rot = mci_pkg::ROT_W'(q);
					end
		end
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------------

	function automatic void check_field(string what, logic [mci_pkg::INDEX_W-1:0] exp,
			logic [mci_pkg::INDEX_W-1:0] act);
		if (exp !== act) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp, act);
		end
	endfunction

	// The receiver cannot hold results off: take every done strobe as it comes
	// and compare it with the oldest expectation.
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with none pending: expected nothing, got %0b/%0d/%0d",
					$time, found, marker_id, rotation_found);
			end else begin
				want = pending.pop_front();
				check_field("found", mci_pkg::INDEX_W'(want.hit),
					mci_pkg::INDEX_W'(found));
				check_field("marker_id", want.id, marker_id);
				check_field("rotation_found", mci_pkg::INDEX_W'(want.rot),
					mci_pkg::INDEX_W'(rotation_found));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Drivers: every input changes on the falling edge only
	// ---------------------------------------------------------------------

	// Present a word and hold it until the block takes it (start high, busy
	// low at a rising edge). Leave start high: the caller drops it or follows
	// with the next word, so a back-to-back stream never dips.
	task automatic send_word(input logic req, input logic [mci_pkg::INDEX_W-1:0] slot,
			input logic [mci_pkg::CELLS_W-1:0] cells, input logic typed,
			input outcome_t want);
		outcome_t got;
		@(negedge clk);
		start       <= 1'b1;
		req_type    <= req;
		entry_index <= slot;
		cell_bits   <= cells;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		got = predict_word(req, slot, cells);
		if (typed)
			got = want;
		pending.insert(pending.size(), got);
		n_words++;
		if (req == mci_pkg::REQ_LOAD)
			n_loads++;
		else
			n_idents++;
		if (got.hit)
			n_hits++;
	endtask

	// One idle cycle: drop start and scramble the payload, which must be ignored.
	task automatic idle_cycle();
		@(negedge clk);
		start       <= 1'b0;
		req_type    <= 1'($urandom);
		entry_index <= mci_pkg::INDEX_W'($urandom);
		cell_bits   <= {$urandom, $urandom};
	endtask

	// Drop start and wait until every expected result has come back.
	task automatic hold_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
	endtask

	// Write one register; only called with nothing in flight.
	task automatic write_reg(input logic [mci_pkg::CFG_IDX_W-1:0] idx,
			input logic [mci_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			mci_pkg::REG_MARKER_SIDE:      m_side   = val[mci_pkg::SIDE_W-1:0];
			mci_pkg::REG_ACTIVE_ENTRIES:   m_active = val[mci_pkg::ENTRIES_W-1:0];
			mci_pkg::REG_CORRECTION_LIMIT: m_limit  = val[mci_pkg::LIMIT_W-1:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	// Script builders for the directed part.
	function automatic void add_cfg(logic [mci_pkg::CFG_IDX_W-1:0] idx,
			logic [mci_pkg::CFG_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.is_cfg  = 1'b1;
		r.reg_idx = idx;
		r.wval    = val;
		script.insert(script.size(), r);
	endfunction

	function automatic void add_word(logic req, logic [mci_pkg::INDEX_W-1:0] slot,
			logic [mci_pkg::CELLS_W-1:0] cells, logic typed, outcome_t want);
		stim_row_t r;
		r = '0;
		r.req   = req;
		r.slot  = slot;
		r.cells = cells;
		r.typed = typed;
		r.want  = want;
		script.insert(script.size(), r);
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------

	initial begin
		stim_row_t                   row;
		logic                        req;
		logic [mci_pkg::INDEX_W-1:0] slot;
		logic [mci_pkg::CELLS_W-1:0] cells;
		int unsigned                 side, n, nflip, pct;
		int                          roll;

		// every input known from time zero; hold reset, then release it on a falling edge
		arst_n      <= 1'b0;
		start       <= 1'b0;
		req_type    <= mci_pkg::REQ_LOAD;
		entry_index <= '0;
		cell_bits   <= '0;
		cfg_we      <= 1'b0;
		cfg_index   <= mci_pkg::REG_MARKER_SIDE;
		cfg_wdata   <= '0;
		m_side   = mci_pkg::SIDE_W'(mci_pkg::MIN_SIDE);
		m_active = '0;
		m_limit  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table. Typed expectations only where obvious: nothing
		// searched with no active entries, all loads, and exact hits whose turns all agree.
		add_word(mci_pkg::REQ_IDENT, 12'd0, 64'h0, 1'b1, '0);
		add_word(mci_pkg::REQ_IDENT, 12'hFFF, '1, 1'b1, '0);
		add_word(mci_pkg::REQ_LOAD, 12'd0, '1, 1'b1, '0);
		// upper cells set but beyond the 4x4 grid: stored as all zero
		add_word(mci_pkg::REQ_LOAD, 12'd1, 64'hFFFF_FFFF_FFFF_0000, 1'b1, '0);
		add_word(mci_pkg::REQ_LOAD, 12'd2, 64'h1, 1'b1, '0);
		add_word(mci_pkg::REQ_LOAD, 12'd3, 64'h8421, 1'b1, '0);
		add_cfg(mci_pkg::REG_ACTIVE_ENTRIES, 13'd4);
		// uniform grids match in every turn: the last turn is reported
		add_word(mci_pkg::REQ_IDENT, 12'd0, '1, 1'b1, '{1'b1, 12'd0, 2'd3});
		add_word(mci_pkg::REQ_IDENT, 12'd0, 64'hABCD_0000_0000_0000, 1'b1,
			'{1'b1, 12'd1, 2'd3});
		add_word(mci_pkg::REQ_IDENT, 12'd5, 64'h1, 1'b0, '0);
		add_word(mci_pkg::REQ_IDENT, 12'd5, 64'h8000, 1'b0, '0);
		add_word(mci_pkg::REQ_IDENT, 12'd5, 64'h1000, 1'b0, '0);
		// one bit from the blank entry, equal in every turn: first turn wins
		add_cfg(mci_pkg::REG_CORRECTION_LIMIT, 13'd1);
		add_word(mci_pkg::REQ_IDENT, 12'd0, 64'h2, 1'b0, '0);
		add_word(mci_pkg::REQ_IDENT, 12'd0, 64'h8421, 1'b0, '0);
		// widest limit, written with every data bit set
		add_cfg(mci_pkg::REG_CORRECTION_LIMIT, 13'h1FFF);
		add_word(mci_pkg::REQ_IDENT, 12'd0, 64'h5555, 1'b0, '0);
		// side above the maximum runs as 8x8; old entries keep their 4x4 layout
		add_cfg(mci_pkg::REG_MARKER_SIDE, 13'd15);
		add_word(mci_pkg::REQ_LOAD, 12'hFFF, '1, 1'b1, '0);
		add_word(mci_pkg::REQ_LOAD, 12'd3, 64'h8000_0000_0000_0001, 1'b1, '0);
		add_word(mci_pkg::REQ_IDENT, 12'd0, 64'h8000_0000_0000_0001, 1'b0, '0);
		add_cfg(mci_pkg::REG_CORRECTION_LIMIT, 13'd0);
		add_word(mci_pkg::REQ_IDENT, 12'd0, 64'h8000_0000_0000_0001, 1'b0, '0);
		// side below the minimum runs as 4x4; the spare index must not stick
		add_cfg(mci_pkg::REG_MARKER_SIDE, 13'd0);
		add_cfg(REG_UNUSED, 13'h1FFF);
		add_word(mci_pkg::REQ_IDENT, 12'd0, 64'h1, 1'b0, '0);
		add_cfg(mci_pkg::REG_ACTIVE_ENTRIES, 13'd0);
		add_word(mci_pkg::REQ_IDENT, 12'd0, '1, 1'b1, '0);

		foreach (script[i]) begin
			row = script[i];
			if (row.is_cfg) begin
				hold_until_drained();
				write_reg(row.reg_idx, row.wval);
			end else begin
				send_word(row.req, row.slot, row.cells, row.typed, row.want);
			end
		end

		// Fill the low slots at 8x8; every search from here on stays within
		// them. Loads stream one per cycle.
		hold_until_drained();
		write_reg(mci_pkg::REG_MARKER_SIDE, 13'd8);
		for (int k = 0; k < FILL_WORDS; k++)
			send_word(mci_pkg::REQ_LOAD, mci_pkg::INDEX_W'(k), {$urandom, $urandom},
				1'b0, '0);

		// Random phases: the first two search every filled slot, the rest a
		// random depth. The receiver cannot stall, so only the sender idles.
		for (int p = 0; p < NUM_PHASES; p++) begin
			hold_until_drained();
			case (p)
				0: begin
					write_reg(mci_pkg::REG_MARKER_SIDE, 13'd8);
					write_reg(mci_pkg::REG_ACTIVE_ENTRIES, mci_pkg::CFG_W'(FILL_WORDS));
					write_reg(mci_pkg::REG_CORRECTION_LIMIT, 13'd31);
				end
				1: begin
					write_reg(mci_pkg::REG_MARKER_SIDE, 13'd4);
					write_reg(mci_pkg::REG_ACTIVE_ENTRIES, mci_pkg::CFG_W'(FILL_WORDS));
					write_reg(mci_pkg::REG_CORRECTION_LIMIT, 13'd0);
				end
				default: begin
					write_reg(mci_pkg::REG_MARKER_SIDE,
						mci_pkg::CFG_W'($urandom_range(15)));
					write_reg(mci_pkg::REG_ACTIVE_ENTRIES,
						($urandom_range(9) == 0) ? 13'd0 :
						mci_pkg::CFG_W'($urandom_range(FILL_WORDS, 1)));
					write_reg(mci_pkg::REG_CORRECTION_LIMIT,
						$urandom_range(1) ? 13'd0 : mci_pkg::CFG_W'($urandom_range(31, 1)));
				end
			endcase
			write_reg(REG_UNUSED, mci_pkg::CFG_W'($urandom));
			pct = idle_pct[p % 3];

			for (int k = 0; k < PHASE_WORDS; k++) begin
				while ($urandom_range(99) < pct)
					idle_cycle();
				// hold off now and then until the block has fully drained
				if ((p == 2 && k == PHASE_WORDS / 2) || $urandom_range(99) < 4)
					hold_until_drained();

				side  = clamp_side(m_side);
				n     = (int'(m_active) > MAX_ENTRIES) ? 32'(MAX_ENTRIES) : 32'(m_active);
				slot  = mci_pkg::INDEX_W'($urandom);
				roll  = $urandom_range(99);
				if (roll < 20) begin
					// reload a searched slot mostly, anywhere sometimes
					req   = mci_pkg::REQ_LOAD;
					if (n > 0 && $urandom_range(9) != 0)
						slot = mci_pkg::INDEX_W'($urandom_range(n - 1));
					cells = {$urandom, $urandom};
				end else if (roll < 85 && n > 0) begin
					// take a stored turn, flip a few cells, junk the unused cells
					req   = mci_pkg::REQ_IDENT;
					cells = code_tab[$urandom_range(n - 1) * mci_pkg::NUM_ROT +
						$urandom_range(3)];
					nflip = $urandom_range(3);
					for (int f = 0; f < nflip; f++)
						cells[$urandom_range(side * side - 1)] ^= 1'b1;
					cells = cells | ({$urandom, $urandom} & ~grid_mask(side));
				end else begin
					req   = mci_pkg::REQ_IDENT;
					cells = {$urandom, $urandom};
				end
				send_word(req, slot, cells, 1'b0, '0);
			end
		end

		// Drain, then give a late or spurious strobe a full scan to show up.
		hold_until_drained();
		repeat (MAX_ENTRIES + 8) @(posedge clk);
		if (pending.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, pending.size());
		end

		$display("covered %0d words: %0d loads, %0d identifies, %0d expected matches",
			n_words, n_loads, n_idents, n_hits);
		$display("over %0d register writes, %0d directed rows and %0d random phases",
			n_cfg, script.size(), NUM_PHASES);
		if (errors == 0)
			$display("marker_codeword_identify_unit_test: clean");
		else
			$display("marker_codeword_identify_unit_test: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
design/mci_pkg.sv
design/mci_ctrl.sv
design/mci_datapath.sv
design/marker_codeword_identify_unit.sv
tb/marker_codeword_identify_unit_test.sv
